/* sv/nfsil_pkg.sv */
`default_nettype none
package nfsil_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = 16;
   localparam int DIST_W   = 24;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic insert;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic count_zero;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

/* sv/nfsil_ctrl.sv */
`default_nettype none
module nfsil_ctrl
   import nfsil_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_in_view,
   input  wire logic       req_last_of_batch,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_take;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign cmd.insert = req_take && req_in_view && !status.full;
   assign cmd.pop    = (state_ff == ST_EMIT) && !status.count_zero && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_last_of_batch) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.count_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* sv/nfsil_dp.sv */
`default_nettype none
module nfsil_dp
   import nfsil_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [IDX_W-1:0]  req_item_index,
   input  wire logic [DIST_W-1:0] req_distance,
   input  wire cmd_type           cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [IDX_W-1:0]       rsp_sorted_index,
   output logic [DIST_W-1:0]      rsp_sorted_distance,
   output logic                   rsp_last_entry
);

   logic [IDX_W-1:0]  idx_ff  [CAPACITY];
   logic [DIST_W-1:0] dist_ff [CAPACITY];
   logic [IDX_W-1:0]  idx_in  [CAPACITY];
   logic [DIST_W-1:0] dist_in [CAPACITY];
   logic [CAPACITY-1:0] greater;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [DIST_W-1:0] rsp_distance_ff;
   logic              rsp_last_ff;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      assign greater[k] = (count_ff > CNT_W'(k)) && (dist_ff[k] > req_distance);

      always_comb begin
         idx_in[k]  = idx_ff[k];
         dist_in[k] = dist_ff[k];
         if (cmd.insert) begin
            if (k > 0 && greater[(k > 0) ? k - 1 : 0]) begin
               idx_in[k]  = idx_ff[(k > 0) ? k - 1 : 0];
               dist_in[k] = dist_ff[(k > 0) ? k - 1 : 0];
            end else if (greater[k] || count_ff == CNT_W'(k)) begin
               idx_in[k]  = req_item_index;
               dist_in[k] = req_distance;
            end
         end else if (cmd.pop && k < CAPACITY - 1) begin
            idx_in[k]  = idx_ff[(k < CAPACITY - 1) ? k + 1 : k];
            dist_in[k] = dist_ff[(k < CAPACITY - 1) ? k + 1 : k];
         end
      end

      always_ff @(posedge clock) begin
         idx_ff[k]  <= idx_in[k];
         dist_ff[k] <= dist_in[k];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rsp_index_ff    <= idx_ff[0];
         rsp_distance_ff <= dist_ff[0];
         rsp_last_ff     <= (count_ff == CNT_W'(1));
      end
   end

   assign status.full       = (count_ff == CNT_W'(CAPACITY));
   assign status.count_zero = (count_ff == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sorted_index    = rsp_index_ff;
   assign rsp_sorted_distance = rsp_distance_ff;
   assign rsp_last_entry      = rsp_last_ff;

endmodule
`default_nettype wire

/* sv/nearest_first_sorted_insert_list_core.sv */
// Nearest-first bounded insertion list. Each accepted item that is in view is
// inserted into a chain of 32 sorted cells (ascending distance, equal
// distances in arrival order); in-view items beyond 32 are dropped until the
// batch ends. An item with last_of_batch set causes the list, including that
// item if it is in view, to be sent out nearest first, one entry per cycle
// while the output is not stalled, with last_entry marking the final one;
// the list is then empty. An item is taken every cycle outside of output;
// during output req_stall stays high until the list has been emptied, which
// takes longer while rsp_stall holds back a result.
// An empty list at batch end yields no transfer.
`default_nettype none
module nearest_first_sorted_insert_list_core
   import nfsil_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [IDX_W-1:0]  req_item_index,
   input  wire logic [DIST_W-1:0] req_distance,
   input  wire logic              req_in_view,
   input  wire logic              req_last_of_batch,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [IDX_W-1:0]       rsp_sorted_index,
   output logic [DIST_W-1:0]      rsp_sorted_distance,
   output logic                   rsp_last_entry
);

   cmd_type    cmd;
   status_type status;

   nfsil_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_in_view       (req_in_view),
      .req_last_of_batch (req_last_of_batch),
      .req_stall         (req_stall),
      .status            (status),
      .cmd               (cmd)
   );

   nfsil_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_item_index      (req_item_index),
      .req_distance        (req_distance),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sorted_index    (rsp_sorted_index),
      .rsp_sorted_distance (rsp_sorted_distance),
      .rsp_last_entry      (rsp_last_entry)
   );

endmodule
`default_nettype wire

/* sv/nfsil_chk.sv */
`default_nettype none
module nfsil_chk
   import nfsil_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              req_last_of_batch,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [IDX_W-1:0]  rsp_sorted_index,
   input wire logic [DIST_W-1:0] rsp_sorted_distance,
   input wire logic              rsp_last_entry
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sorted_index)
         && $stable(rsp_sorted_distance) && $stable(rsp_last_entry))
      else $error("stalled result transfer changed");

   a_mid_list_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_entry |-> req_stall)
      else $error("input taken while list output in progress");

   a_no_batch_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_last_of_batch |=> !req_stall)
      else $error("stall raised without batch end");

   a_rsp_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("result appeared outside list output");

endmodule

bind nearest_first_sorted_insert_list_core nfsil_chk u_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_last_of_batch   (req_last_of_batch),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_sorted_index    (rsp_sorted_index),
   .rsp_sorted_distance (rsp_sorted_distance),
   .rsp_last_entry      (rsp_last_entry)
);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
   import nfsil_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] distance;
      logic              vis;
      logic              last;
      logic              wait_idle;
   } offer_type;

   typedef struct {
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] distance;
      logic              last;
   } entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [IDX_W-1:0]  req_item_index = '0;
   logic [DIST_W-1:0] req_distance = '0;
   logic              req_in_view = 1'b0;
   logic              req_last_of_batch = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [IDX_W-1:0]  rsp_sorted_index;
   logic [DIST_W-1:0] rsp_sorted_distance;
   logic              rsp_last_entry;

   offer_type         offer_q[$];
   entry_type         emitted_q[$];
   logic [IDX_W-1:0]  list_idx [CAPACITY];
   logic [DIST_W-1:0] list_dist [CAPACITY];
   int                list_count = 0;
   int                mismatches = 0;
   offer_type         cur_offer;
   int                burst_left = 0;
   int                gap_left = 0;
   int                hold_left = 0;
   bit                hold_done = 1'b0;
   int                pattern_left = 0;
   int                pattern_mode = 0;
   int                seen_transfers = 0;

   nearest_first_sorted_insert_list_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_item_index      (req_item_index),
      .req_distance        (req_distance),
      .req_in_view         (req_in_view),
      .req_last_of_batch   (req_last_of_batch),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sorted_index    (rsp_sorted_index),
      .rsp_sorted_distance (rsp_sorted_distance),
      .rsp_last_entry      (rsp_last_entry)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void insert_nearest(offer_type it);
      int        pos;
      entry_type e;
      if (it.vis && list_count < CAPACITY) begin
         pos = list_count;
         for (int k = list_count - 1; k >= 0; k--)
            if (list_dist[k] > it.distance) pos = k;
         for (int k = list_count; k > pos; k--) begin
            list_idx[k]  = list_idx[k-1];
            list_dist[k] = list_dist[k-1];
         end
         list_idx[pos]  = it.idx;
         list_dist[pos] = it.distance;
         list_count++;
      end
      if (it.last) begin
         for (int k = 0; k < list_count; k++) begin
            e.idx      = list_idx[k];
            e.distance = list_dist[k];
            e.last     = (k == list_count - 1);
            emitted_q.push_back(e);
         end
         list_count = 0;
      end
   endfunction

   task automatic add_offer(input logic [IDX_W-1:0] idx, input logic [DIST_W-1:0] distance,
                            input logic vis, input logic last, input logic wait_idle);
      offer_type it;
      it.idx       = idx;
      it.distance  = distance;
      it.vis       = vis;
      it.last      = last;
      it.wait_idle = wait_idle;
      offer_q.push_back(it);
   endtask

   // sender: bursts with random gaps; hold payload while stalled
   always @(posedge clock) begin : drive
      logic offer;
      offer = 1'b0;
      if (reset) begin
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall)
            insert_nearest(cur_offer);
         if (req_valid && req_stall) begin
            offer = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (offer_q.size() > 0) begin
            if (!(offer_q[0].wait_idle && (emitted_q.size() != 0 || rsp_valid))) begin
               cur_offer = offer_q.pop_front();
               offer = 1'b1;
               req_item_index    <= cur_offer.idx;
               req_distance      <= cur_offer.distance;
               req_in_view       <= cur_offer.vis;
               req_last_of_batch <= cur_offer.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= offer;
   end

   // receiver: own stall pattern plus one long hold-off
   always @(posedge clock) begin : receive
      logic stall_next;
      stall_next = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) seen_transfers++;
         if (!hold_done && seen_transfers >= 220) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(8, 80);
         end else begin
            pattern_left--;
         end
         case (pattern_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            2: stall_next = ($urandom_range(0, 9) < 6);
            default: stall_next = ~rsp_stall;
         endcase
         if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
         end
      end
      rsp_stall <= stall_next;
   end

   always @(posedge clock) begin : check
      entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (emitted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: index %h distance %h last %b",
                        rsp_sorted_index, rsp_sorted_distance, rsp_last_entry);
         end else begin
            want = emitted_q.pop_front();
            if (rsp_sorted_index !== want.idx || rsp_sorted_distance !== want.distance ||
                rsp_last_entry !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%h/%b, got %h/%h/%b",
                           want.idx, want.distance, want.last,
                           rsp_sorted_index, rsp_sorted_distance, rsp_last_entry);
            end
         end
      end
   end

   initial begin : stimulus
      int                counted;
      int                bsize;
      int                dmode;
      int                noise;
      int                batch_no;
      logic [DIST_W-1:0] d;
      logic              vis;
      logic              lst;

      add_offer(16'h1234, 24'd5, 1'b0, 1'b1, 1'b0);
      add_offer(16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0000, 24'h000000, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0007, 24'd100, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0008, 24'd100, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0009, 24'd100, 1'b0, 1'b0, 1'b0);
      add_offer(16'h000A, 24'd50, 1'b1, 1'b0, 1'b0);
      add_offer(16'h000B, 24'd100, 1'b1, 1'b1, 1'b0);
      add_offer(16'h0014, 24'd3, 1'b1, 1'b0, 1'b1);
      add_offer(16'h0015, 24'd1, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0016, 24'd2, 1'b0, 1'b1, 1'b0);
      add_offer(16'hAAAA, 24'h555555, 1'b1, 1'b1, 1'b0);
      add_offer(16'h5555, 24'hAAAAAA, 1'b1, 1'b0, 1'b0);
      add_offer(16'h8000, 24'h800000, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0001, 24'h000001, 1'b1, 1'b0, 1'b0);
      add_offer(16'h7FFF, 24'h7FFFFF, 1'b0, 1'b1, 1'b0);
      add_offer(16'h0001, 24'h000001, 1'b0, 1'b1, 1'b0);
      add_offer(16'h0030, 24'd9, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0031, 24'd8, 1'b1, 1'b0, 1'b0);
      add_offer(16'h0032, 24'd7, 1'b1, 1'b1, 1'b0);

      counted  = 20;
      batch_no = 0;
      while (counted < 460) begin
         if ($urandom_range(0, 15) == 0) begin
            lst = ($urandom_range(0, 1) == 1);
            add_offer(IDX_W'($urandom_range(0, 65535)),
                      DIST_W'($urandom_range(0, 24'hFFFFFF)), 1'b0, lst, 1'b0);
            counted++;
         end
         if (batch_no == 2)
            bsize = 40;
         else if ($urandom_range(0, 9) == 0)
            bsize = $urandom_range(33, 40);
         else
            bsize = $urandom_range(1, 12);
         dmode = $urandom_range(0, 3);
         noise = ($urandom_range(0, 4) == 0) ? 50 : 10;
         for (int n = 0; n < bsize; n++) begin
            case (dmode)
               0: d = DIST_W'($urandom_range(0, 7));
               1: d = DIST_W'($urandom_range(0, 24'hFFFFFF));
               2: case ($urandom_range(0, 4))
                     0: d = 24'h000000;
                     1: d = 24'hFFFFFF;
                     2: d = 24'hFFFFFE;
                     3: d = 24'h000001;
                     default: d = DIST_W'($urandom_range(0, 24'hFFFFFF));
                  endcase
               default: d = DIST_W'($urandom_range(0, 255));
            endcase
            vis = (batch_no == 2) || ($urandom_range(0, 99) >= noise);
            lst = (n == bsize - 1);
            add_offer(IDX_W'($urandom_range(0, 65535)), d, vis, lst,
                      (n == 0) && (batch_no == 15 || $urandom_range(0, 39) == 0));
            counted++;
         end
         batch_no++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (offer_q.size() != 0 || req_valid || emitted_q.size() != 0);
      repeat (CAPACITY + 10) @(negedge clock);

      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

/* sim.f */
sv/nfsil_pkg.sv
sv/nfsil_ctrl.sv
sv/nfsil_dp.sv
sv/nearest_first_sorted_insert_list_core.sv
sv/nfsil_chk.sv
tb/sv/tb.sv
